/* design/scfr_pkg.sv */
package scfr_pkg;

	localparam int BYTE_W     = 8;
	localparam int SPEED_W    = 16;
	localparam int FRAME_LEN  = 15;
	localparam int CHECK_POS  = 13;
	localparam int TAIL_POS   = 14;
	localparam int CHAIN_LEN  = CHECK_POS;
	localparam int POS_W      = $clog2(FRAME_LEN + 1);
	localparam int REG_IDX_W  = 1;

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_HEADER = reg_idx_t'(0);
	localparam reg_idx_t REG_TAIL   = reg_idx_t'(1);

	localparam byte_t HEADER_RESET = byte_t'(123);
	localparam byte_t TAIL_RESET   = byte_t'(125);

	localparam pos_t POS_IDLE  = pos_t'(0);
	localparam pos_t POS_FIRST = pos_t'(1);
	localparam pos_t POS_CHECK = pos_t'(CHECK_POS);
	localparam pos_t POS_TAIL  = pos_t'(TAIL_POS);

	typedef struct packed {
		logic  at_tail;
		byte_t xor_value;
	} ctrl_t;

endpackage

/* design/scfr_cell.sv */
module scfr_cell (
	input  logic           clk,
	input  logic           shift,
	input  scfr_pkg::byte_t data_in,
	output scfr_pkg::byte_t data_out
);
	import scfr_pkg::*;

	byte_t data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= data_in;
		end
	end

	assign data_out = data_q;

endmodule

/* design/scfr_ctrl.sv */
module scfr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  scfr_pkg::byte_t rx_byte,
	input  scfr_pkg::byte_t header_byte,
	output scfr_pkg::ctrl_t ctrl
);
	import scfr_pkg::*;

	pos_t  pos_q;
	byte_t xor_q;
	pos_t  pos_d;
	byte_t xor_d;

	always_comb begin
		pos_d = pos_q;
		xor_d = xor_q;
		if (accept) begin
			if (pos_q == POS_IDLE) begin
				if (rx_byte == header_byte) begin
					pos_d = POS_FIRST;
					xor_d = rx_byte;
				end
			end else if (pos_q >= POS_TAIL) begin
				pos_d = POS_IDLE;
				xor_d = '0;
			end else begin
				pos_d = pos_q + pos_t'(1);
				if (pos_q < POS_CHECK) begin
					xor_d = xor_q ^ rx_byte;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
			xor_q <= '0;
		end else begin
			pos_q <= pos_d;
			xor_q <= xor_d;
		end
	end

	assign ctrl.at_tail   = (pos_q == POS_TAIL);
	assign ctrl.xor_value = xor_q;

endmodule

/* design/serial_command_frame_receiver.sv */
// Serial command frame receiver: takes one received byte per transfer and, after
// hunting for the header byte, collects a 15-byte frame (header, flag, status, three
// big-endian signed speeds, four command bytes, XOR check over bytes 0..12, tail).
// The tail byte produces one result transfer with the decoded fields and frame_ok,
// which is 1 only when both the tail and the XOR check match; failed frames are still
// reported. Accepts one byte every cycle while in_ready is high; frame bytes move down a
// 13-cell shift chain and the result is registered as the tail byte is taken. in_ready
// drops only while the tail byte is waiting and the previous result is still held.
// header_byte and tail_byte are written through cfg_we/cfg_index/cfg_data.
module serial_command_frame_receiver (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  scfr_pkg::reg_idx_t          cfg_index,
	input  scfr_pkg::byte_t             cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  scfr_pkg::byte_t             rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        frame_ok,
	output scfr_pkg::byte_t             flag_value,
	output scfr_pkg::byte_t             status_value,
	output logic signed [15:0]          speed_x,
	output logic signed [15:0]          speed_y,
	output logic signed [15:0]          speed_z,
	output scfr_pkg::byte_t             roller_cmd,
	output scfr_pkg::byte_t             mode_cmd,
	output scfr_pkg::byte_t             keep_cmd,
	output scfr_pkg::byte_t             place_cmd
);
	import scfr_pkg::*;

	byte_t header_q;
	byte_t tail_q;
	ctrl_t ctrl;
	logic  accept;
	logic  emit;
	byte_t chain [CHAIN_LEN];

	logic                      out_valid_q;
	logic                      frame_ok_q;
	byte_t                     flag_q;
	byte_t                     status_q;
	logic signed [SPEED_W-1:0] speed_x_q;
	logic signed [SPEED_W-1:0] speed_y_q;
	logic signed [SPEED_W-1:0] speed_z_q;
	byte_t                     roller_q;
	byte_t                     mode_q;
	byte_t                     keep_q;
	byte_t                     place_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			tail_q   <= TAIL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER: header_q <= cfg_data;
				REG_TAIL:   tail_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !ctrl.at_tail || !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign emit     = accept && ctrl.at_tail;

	scfr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.header_byte (header_q),
		.ctrl        (ctrl)
	);

	for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
		if (i == 0) begin : g_head
			scfr_cell u_cell (
				.clk      (clk),
				.shift    (accept),
				.data_in  (rx_byte),
				.data_out (chain[i])
			);
		end else begin : g_body
			scfr_cell u_cell (
				.clk      (clk),
				.shift    (accept),
				.data_in  (chain[i-1]),
				.data_out (chain[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			frame_ok_q <= (rx_byte == tail_q) && (chain[0] == ctrl.xor_value);
			flag_q     <= chain[CHAIN_LEN-1];
			status_q   <= chain[CHAIN_LEN-2];
			speed_x_q  <= {chain[CHAIN_LEN-3], chain[CHAIN_LEN-4]};
			speed_y_q  <= {chain[CHAIN_LEN-5], chain[CHAIN_LEN-6]};
			speed_z_q  <= {chain[CHAIN_LEN-7], chain[CHAIN_LEN-8]};
			roller_q   <= chain[CHAIN_LEN-9];
			mode_q     <= chain[CHAIN_LEN-10];
			keep_q     <= chain[CHAIN_LEN-11];
			place_q    <= chain[CHAIN_LEN-12];
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_ok     = frame_ok_q;
	assign flag_value   = flag_q;
	assign status_value = status_q;
	assign speed_x      = speed_x_q;
	assign speed_y      = speed_y_q;
	assign speed_z      = speed_z_q;
	assign roller_cmd   = roller_q;
	assign mode_cmd     = mode_q;
	assign keep_cmd     = keep_q;
	assign place_cmd    = place_q;

endmodule

/* design/scfr_checker.sv */
module scfr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               frame_ok,
	input scfr_pkg::byte_t    flag_value,
	input scfr_pkg::byte_t    status_value,
	input logic signed [15:0] speed_x,
	input logic signed [15:0] speed_y,
	input logic signed [15:0] speed_z,
	input scfr_pkg::byte_t    roller_cmd,
	input scfr_pkg::byte_t    mode_cmd,
	input scfr_pkg::byte_t    keep_cmd,
	input scfr_pkg::byte_t    place_cmd
);
	import scfr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_ok)
			&& $stable(flag_value) && $stable(status_value)
			&& $stable(speed_x) && $stable(speed_y) && $stable(speed_z)
			&& $stable(roller_cmd) && $stable(mode_cmd)
			&& $stable(keep_cmd) && $stable(place_cmd))
		else $error("result changed while stalled");

	a_rise_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result appeared without an input transfer");

	a_clear_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
		else $error("result held after its transfer");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind serial_command_frame_receiver scfr_checker u_scfr_checker (.*);
